### src/gradient_color_generator_defines.svh
// ---------------------------------------------------------------------------
// gradient color generator assertion macros
// shared clocked assertion forms, disabled while reset is asserted
// ---------------------------------------------------------------------------
`ifndef GRADIENT_COLOR_GENERATOR_DEFINES_SVH
`define GRADIENT_COLOR_GENERATOR_DEFINES_SVH

// property that must hold at every edge
`define GCG_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
	else $error(msg);

// consequence in the cycle after the trigger
`define GCG_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error(msg);

`endif

### src/gcg_pkg.sv
// ---------------------------------------------------------------------------
// gcg_pkg
// widths, palette tables and fixed point constants of the gradient generator
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package gcg_pkg;

	localparam int FRAC_BITS = 16;
	localparam int MAX_LINES = 256;

	localparam int IDX_W = 8;
	localparam int CNT_W = 9;
	localparam int CH_W  = 8;
	localparam int PAL_W = 4;
	localparam int T_W   = FRAC_BITS + 1;
	localparam int D_W   = CNT_W;

	// effective count ceiling given the port width
	localparam int CNT_MAX = (MAX_LINES < (1 << CNT_W) - 1) ? MAX_LINES : (1 << CNT_W) - 1;
	localparam logic [CNT_W-1:0] CNT_CAP = CNT_W'(CNT_MAX);

	localparam logic [T_W-1:0] ONE_FX = {1'b1, {FRAC_BITS{1'b0}}};

	// divider pipeline: quotient bits resolved per stage
	localparam int DIV_STEPS  = 4;
	localparam int DIV_STAGES = (FRAC_BITS + DIV_STEPS - 1) / DIV_STEPS;

	// neon split points
	localparam logic [T_W-1:0] SPLIT_A = T_W'((33 * (longint'(1) << FRAC_BITS)) / 100);
	localparam logic [T_W-1:0] SPLIT_B = T_W'((66 * (longint'(1) << FRAC_BITS)) / 100);

	// exact reciprocals for u/33 and (16u)/17
	localparam int K33   = T_W + 7;
	localparam int M33_W = K33 - 4;
	localparam logic [M33_W-1:0] M33 = M33_W'(((longint'(1) << K33) + 32) / 33);
	localparam int K17   = T_W + 10;
	localparam int M17_W = K17 - 3;
	localparam logic [M17_W-1:0] M17 = M17_W'(((longint'(1) << K17) + 16) / 17);

	localparam int ACC_W = CH_W + T_W + 2;

	typedef logic [PAL_W-1:0] pal_t;

	localparam pal_t PAL_NEON    = 4'd5;
	localparam pal_t PAL_MONO    = 4'd9;
	localparam pal_t PAL_RAINBOW = 4'd10;
	localparam pal_t PAL_COUNT   = 4'd13;

	typedef struct packed {
		logic [CH_W-1:0] r;
		logic [CH_W-1:0] g;
		logic [CH_W-1:0] b;
	} rgb_t;

	typedef struct packed {
		pal_t             pal;
		logic             short_run;
		logic [D_W-1:0]   d;
		logic [D_W-1:0]   rem;
		logic [T_W-1:0]   quo;
	} div_t;

	localparam rgb_t MONO_RGB = '{r: 8'd0, g: 8'd120, b: 8'd255};

	function automatic rgb_t pal_start(input pal_t p);
		rgb_t c;
		case (p)
			4'd0:    c = '{r: 8'd135, g: 8'd206, b: 8'd250};
			4'd1:    c = '{r: 8'd255, g: 8'd69,  b: 8'd0};
			4'd2:    c = '{r: 8'd152, g: 8'd251, b: 8'd152};
			4'd3:    c = '{r: 8'd218, g: 8'd112, b: 8'd214};
			4'd4:    c = '{r: 8'd255, g: 8'd191, b: 8'd0};
			4'd5:    c = '{r: 8'd255, g: 8'd20,  b: 8'd147};
			4'd6:    c = '{r: 8'd173, g: 8'd216, b: 8'd230};
			4'd7:    c = '{r: 8'd255, g: 8'd182, b: 8'd193};
			4'd8:    c = '{r: 8'd34,  g: 8'd139, b: 8'd34};
			4'd10:   c = '{r: 8'd255, g: 8'd0,   b: 8'd0};
			4'd11:   c = '{r: 8'd255, g: 8'd0,   b: 8'd255};
			4'd12:   c = '{r: 8'd192, g: 8'd192, b: 8'd192};
			default: c = MONO_RGB;
		endcase
		return c;
	endfunction

	function automatic rgb_t pal_end(input pal_t p);
		rgb_t c;
		case (p)
			4'd0:    c = '{r: 8'd0,   g: 8'd0,   b: 8'd139};
			4'd1:    c = '{r: 8'd139, g: 8'd0,   b: 8'd0};
			4'd2:    c = '{r: 8'd0,   g: 8'd128, b: 8'd128};
			4'd3:    c = '{r: 8'd75,  g: 8'd0,   b: 8'd130};
			4'd4:    c = '{r: 8'd255, g: 8'd69,  b: 8'd0};
			4'd5:    c = '{r: 8'd0,   g: 8'd191, b: 8'd255};
			4'd6:    c = '{r: 8'd0,   g: 8'd206, b: 8'd209};
			4'd7:    c = '{r: 8'd255, g: 8'd215, b: 8'd0};
			4'd8:    c = '{r: 8'd144, g: 8'd238, b: 8'd144};
			4'd10:   c = '{r: 8'd255, g: 8'd0,   b: 8'd0};
			4'd11:   c = '{r: 8'd139, g: 8'd0,   b: 8'd139};
			4'd12:   c = '{r: 8'd64,  g: 8'd64,  b: 8'd64};
			default: c = MONO_RGB;
		endcase
		return c;
	endfunction

	function automatic rgb_t neon_pt(input logic [1:0] i);
		rgb_t c;
		case (i)
			2'd0:    c = '{r: 8'd255, g: 8'd20,  b: 8'd147};
			2'd1:    c = '{r: 8'd0,   g: 8'd191, b: 8'd255};
			2'd2:    c = '{r: 8'd138, g: 8'd43,  b: 8'd226};
			default: c = '{r: 8'd50,  g: 8'd205, b: 8'd50};
		endcase
		return c;
	endfunction

endpackage

### src/gcg_line_if.sv
// ---------------------------------------------------------------------------
// gcg_line_if
// line position channel: index and count of one line
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

interface gcg_line_if import gcg_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [IDX_W-1:0] line_index;
	logic [CNT_W-1:0] line_count;

	modport source(output valid, line_index, line_count, input ready);
	modport sink(input valid, line_index, line_count, output ready);
endinterface

### src/gcg_color_if.sv
// ---------------------------------------------------------------------------
// gcg_color_if
// color result channel: red, green and blue
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

interface gcg_color_if import gcg_pkg::*; ();
	logic            valid;
	logic            ready;
	logic [CH_W-1:0] red;
	logic [CH_W-1:0] green;
	logic [CH_W-1:0] blue;

	modport source(output valid, red, green, blue, input ready);
	modport sink(input valid, red, green, blue, output ready);
endinterface

### src/gcg_cfg_if.sv
// ---------------------------------------------------------------------------
// gcg_cfg_if
// palette select write channel
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

interface gcg_cfg_if import gcg_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [PAL_W-1:0] gradient_type;

	modport source(output valid, gradient_type, input ready);
	modport sink(input valid, gradient_type, output ready);
endinterface

### src/gcg_div_stage.sv
// ---------------------------------------------------------------------------
// gcg_div_stage
// one registered slice of the restoring divider, DIV_STEPS quotient bits each
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "gradient_color_generator_defines.svh"

module gcg_div_stage import gcg_pkg::*; #(
	parameter int FIRST_BIT = FRAC_BITS - 1
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  div_t in_data,
	output logic out_valid,
	input  logic out_ready,
	output div_t out_data
);

	div_t data_s1;
	logic valid_s1;
	div_t nxt;

	always_comb begin
		logic [D_W:0] r2;
		nxt = in_data;
		r2  = '0;
		for (int s = 0; s < DIV_STEPS; s++) begin
			if (FIRST_BIT - s >= 0) begin
				r2 = {nxt.rem, 1'b0};
				if (r2 >= {1'b0, nxt.d}) begin
					nxt.rem = D_W'(r2 - {1'b0, nxt.d});
					nxt.quo[FIRST_BIT - s] = 1'b1;
				end else begin
					nxt.rem = r2[D_W-1:0];
				end
			end
		end
	end

	assign in_ready = !valid_s1 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_s1 <= nxt;
		end
	end

	assign out_valid = valid_s1;
	assign out_data  = data_s1;

	`GCG_ASSERT(a_rem_below_div, valid_s1 |-> data_s1.rem < data_s1.d, "remainder not below divisor")

endmodule

### src/gcg_div.sv
// ---------------------------------------------------------------------------
// gcg_div
// operand prep and pipelined divide giving t = min(index, count - 1) * 2^frac / (count - 1)
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module gcg_div import gcg_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [IDX_W-1:0] line_index,
	input  logic [CNT_W-1:0] line_count,
	input  pal_t             pal,
	output logic             out_valid,
	input  logic             out_ready,
	output div_t             out_data
);

	div_t data_s1;
	logic valid_s1;
	div_t prep;

	logic [DIV_STAGES:0] v_c;
	logic [DIV_STAGES:0] r_c;
	div_t                d_c [DIV_STAGES+1];

	always_comb begin
		logic [CNT_W-1:0] cnt_eff;
		logic [D_W-1:0]   idx_w;
		cnt_eff = (line_count > CNT_CAP) ? CNT_CAP : line_count;
		idx_w   = D_W'(line_index);
		prep           = '0;
		prep.pal       = pal;
		prep.short_run = (cnt_eff <= CNT_W'(1));
		prep.d         = prep.short_run ? D_W'(1) : D_W'(cnt_eff - CNT_W'(1));
		if (idx_w > prep.d) begin
			idx_w = prep.d;
		end
		// index never exceeds the divisor, so the integer bit is just equality
		if (idx_w == prep.d) begin
			prep.quo[FRAC_BITS] = 1'b1;
			prep.rem            = '0;
		end else begin
			prep.rem = idx_w;
		end
	end

	assign in_ready = !valid_s1 || r_c[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_s1 <= prep;
		end
	end

	assign v_c[0] = valid_s1;
	assign d_c[0] = data_s1;

	for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
		gcg_div_stage #(
			.FIRST_BIT(FRAC_BITS - 1 - DIV_STEPS * k)
		) u_stage (
			.clk      (clk),
			.arst_n   (arst_n),
			.in_valid (v_c[k]),
			.in_ready (r_c[k]),
			.in_data  (d_c[k]),
			.out_valid(v_c[k+1]),
			.out_ready(r_c[k+1]),
			.out_data (d_c[k+1])
		);
	end

	assign out_valid       = v_c[DIV_STAGES];
	assign r_c[DIV_STAGES] = out_ready;
	assign out_data        = d_c[DIV_STAGES];

endmodule

### src/gcg_color.sv
// ---------------------------------------------------------------------------
// gcg_color
// palette mapping: neon segment scale, hsv sectors, blend and truncation
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "gradient_color_generator_defines.svh"

module gcg_color import gcg_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  div_t in_data,
	output logic out_valid,
	input  logic out_ready,
	output rgb_t out_data
);

	localparam int P33_W = T_W + M33_W;
	localparam int P17_W = T_W + 4 + M17_W;
	localparam int LOC_W = T_W + 2;

	// stage 1: neon segment offset and reciprocal products
	logic             valid_s1;
	pal_t             pal_s1;
	logic             short_s1;
	logic [T_W-1:0]   t_s1;
	logic [1:0]       seg_s1;
	logic [T_W-1:0]   u_s1;
	logic [P33_W-1:0] p33_s1;
	logic [P17_W-1:0] p17_s1;

	// stage 2: blend endpoints and weight
	logic           valid_s2;
	rgb_t           a_s2;
	rgb_t           b_s2;
	logic [T_W-1:0] w_s2;

	// stage 3: blend accumulators
	logic                    valid_s3;
	logic signed [ACC_W-1:0] acc_r_s3;
	logic signed [ACC_W-1:0] acc_g_s3;
	logic signed [ACC_W-1:0] acc_b_s3;

	// stage 4: output register
	logic valid_s4;
	rgb_t color_s4;

	logic en_s1, en_s2, en_s3, en_s4;

	assign en_s4    = !valid_s4 || out_ready;
	assign en_s3    = !valid_s3 || en_s4;
	assign en_s2    = !valid_s2 || en_s3;
	assign en_s1    = !valid_s1 || en_s2;
	assign in_ready = en_s1;

	logic [1:0]     seg_c;
	logic [T_W-1:0] u_c;

	always_comb begin
		if (in_data.quo < SPLIT_A) begin
			seg_c = 2'd0;
			u_c   = in_data.quo;
		end else if (in_data.quo < SPLIT_B) begin
			seg_c = 2'd1;
			u_c   = in_data.quo - SPLIT_A;
		end else begin
			seg_c = 2'd2;
			u_c   = in_data.quo - SPLIT_B;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1 && in_valid) begin
			pal_s1   <= in_data.pal;
			short_s1 <= in_data.short_run;
			t_s1     <= in_data.quo;
			seg_s1   <= seg_c;
			u_s1     <= u_c;
			p33_s1   <= P33_W'(u_c) * P33_W'(M33);
			p17_s1   <= P17_W'({u_c, 4'b0000}) * P17_W'(M17);
		end
	end

	rgb_t           a_c;
	rgb_t           b_c;
	logic [T_W-1:0] w_c;
	rgb_t           rb_c;

	always_comb begin
		logic [LOC_W-1:0]   loc;
		logic [T_W+2:0]     h;
		logic [2:0]         sector;
		logic [T_W-1:0]     fx;
		logic [T_W-1:0]     x;
		logic [T_W+7:0]     xw;
		logic [CH_W-1:0]    xs;
		logic [T_W-1:0]     loc_sat;

		// 100u/33 = 3u + u/33, 100u/34 = 2u + 16u/17
		if (seg_s1 == 2'd2) begin
			loc = LOC_W'({u_s1, 1'b0}) + LOC_W'(p17_s1 >> K17);
		end else begin
			loc = LOC_W'({u_s1, 1'b0}) + LOC_W'(u_s1) + LOC_W'(p33_s1 >> K33);
		end
		loc_sat = (loc > LOC_W'(ONE_FX)) ? ONE_FX : loc[T_W-1:0];

		// hue in sextants
		h      = {t_s1, 2'b00} + (T_W+3)'({t_s1, 1'b0});
		sector = h[FRAC_BITS+2:FRAC_BITS];
		fx     = {1'b0, h[FRAC_BITS-1:0]};
		if (sector >= 3'd6) begin
			sector = 3'd5;
			fx     = ONE_FX;
		end
		x  = sector[0] ? (ONE_FX - fx) : fx;
		xw = {x, 8'h00} - (T_W+8)'(x);
		xs = xw[FRAC_BITS+7:FRAC_BITS];
		case (sector)
			3'd0:    rb_c = '{r: 8'd255, g: xs,     b: 8'd0};
			3'd1:    rb_c = '{r: xs,     g: 8'd255, b: 8'd0};
			3'd2:    rb_c = '{r: 8'd0,   g: 8'd255, b: xs};
			3'd3:    rb_c = '{r: 8'd0,   g: xs,     b: 8'd255};
			3'd4:    rb_c = '{r: xs,     g: 8'd0,   b: 8'd255};
			default: rb_c = '{r: 8'd255, g: 8'd0,   b: xs};
		endcase

		if (pal_s1 >= PAL_COUNT) begin
			a_c = MONO_RGB;
			b_c = MONO_RGB;
			w_c = '0;
		end else if (short_s1) begin
			a_c = pal_start(pal_s1);
			b_c = a_c;
			w_c = '0;
		end else if (pal_s1 == PAL_NEON) begin
			a_c = neon_pt(seg_s1);
			b_c = neon_pt(seg_s1 + 2'd1);
			w_c = loc_sat;
		end else if (pal_s1 == PAL_RAINBOW) begin
			a_c = rb_c;
			b_c = rb_c;
			w_c = '0;
		end else begin
			a_c = pal_start(pal_s1);
			b_c = pal_end(pal_s1);
			w_c = t_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s2 && valid_s1) begin
			a_s2 <= a_c;
			b_s2 <= b_c;
			w_s2 <= w_c;
		end
	end

	function automatic logic signed [ACC_W-1:0] blend_ch(
		input logic [CH_W-1:0] a,
		input logic [CH_W-1:0] b,
		input logic [T_W-1:0]  w
	);
		logic signed [CH_W:0]    diff;
		logic signed [T_W:0]     ws;
		logic signed [ACC_W-1:0] base;
		diff = $signed({1'b0, b}) - $signed({1'b0, a});
		ws   = $signed({1'b0, w});
		base = $signed({{(ACC_W-CH_W-FRAC_BITS){1'b0}}, a, {FRAC_BITS{1'b0}}});
		return base + ACC_W'(diff * ws);
	endfunction

	always_ff @(posedge clk) begin
		if (en_s3 && valid_s2) begin
			acc_r_s3 <= blend_ch(a_s2.r, b_s2.r, w_s2);
			acc_g_s3 <= blend_ch(a_s2.g, b_s2.g, w_s2);
			acc_b_s3 <= blend_ch(a_s2.b, b_s2.b, w_s2);
		end
	end

	function automatic logic [CH_W-1:0] trunc_ch(input logic signed [ACC_W-1:0] acc);
		return acc[ACC_W-1] ? '0 : acc[FRAC_BITS+CH_W-1:FRAC_BITS];
	endfunction

	always_ff @(posedge clk) begin
		if (en_s4 && valid_s3) begin
			color_s4.r <= trunc_ch(acc_r_s3);
			color_s4.g <= trunc_ch(acc_g_s3);
			color_s4.b <= trunc_ch(acc_b_s3);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (en_s1) begin
				valid_s1 <= in_valid;
			end
			if (en_s2) begin
				valid_s2 <= valid_s1;
			end
			if (en_s3) begin
				valid_s3 <= valid_s2;
			end
			if (en_s4) begin
				valid_s4 <= valid_s3;
			end
		end
	end

	assign out_valid = valid_s4;
	assign out_data  = color_s4;

	`GCG_ASSERT(a_weight_max, valid_s2 |-> w_s2 <= ONE_FX, "blend weight above one")
	`GCG_ASSERT(a_acc_nonneg, valid_s3 |-> !(acc_r_s3[ACC_W-1] || acc_g_s3[ACC_W-1] || acc_b_s3[ACC_W-1]), "negative blend")
	`GCG_ASSERT_NEXT(a_s2_advance, valid_s2 && en_s3, valid_s3, "stage two item dropped")

endmodule

### src/gradient_color_generator.sv
// ---------------------------------------------------------------------------
// gradient_color_generator
// line transfer to color valid through prep, 4 divide stages, 4 color
// stages; one line per cycle sustained unless color.ready is held low;
// the divider stages resolving 4 quotient bits each set the depth
// reset clears all valid bits and selects the mono palette
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module gradient_color_generator import gcg_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	gcg_line_if.sink  line,
	gcg_color_if.source color,
	gcg_cfg_if.sink   cfg
);

	pal_t gtype_q;

	logic div_valid;
	logic div_ready;
	div_t div_data;
	rgb_t rgb;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gtype_q <= PAL_MONO;
		end else if (cfg.valid) begin
			gtype_q <= cfg.gradient_type;
		end
	end

	gcg_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (line.valid),
		.in_ready  (line.ready),
		.line_index(line.line_index),
		.line_count(line.line_count),
		.pal       (gtype_q),
		.out_valid (div_valid),
		.out_ready (div_ready),
		.out_data  (div_data)
	);

	gcg_color u_color (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (div_valid),
		.in_ready (div_ready),
		.in_data  (div_data),
		.out_valid(color.valid),
		.out_ready(color.ready),
		.out_data (rgb)
	);

	assign color.red   = rgb.r;
	assign color.green = rgb.g;
	assign color.blue  = rgb.b;

endmodule
